// ===== design/kpps_pkg.sv =====
// shared types and constants of the k-means++ seeding unit
package kpps_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned RandW    = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_NUM_POINTS  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_DIMS    = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_NUM_CENTERS = 8'd2;

  localparam logic [10:0] NUM_POINTS_RST  = 11'd1024;
  localparam logic [4:0]  NUM_DIMS_RST    = 5'd16;
  localparam logic [6:0]  NUM_CENTERS_RST = 7'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNI,
    ST_P1,
    ST_P1_DRAIN,
    ST_MUL,
    ST_MUL2,
    ST_P2,
    ST_FETCH,
    ST_FETCH_DRAIN,
    ST_EMIT
  } state_e;

endpackage

// ===== design/kpps_if.sv =====
// handshake channels of the k-means++ seeding unit
interface kpps_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [9:0]         point_index;
  logic [3:0]         dim_index;
  logic signed [15:0] coord;
  logic [31:0]        rand_fraction;
  modport source (output valid, req_type, point_index, dim_index, coord, rand_fraction,
                  input ready);
  modport sink (input valid, req_type, point_index, dim_index, coord, rand_fraction,
                output ready);
endinterface

interface kpps_res_if;
  logic               valid;
  logic               ready;
  logic [5:0]         center_number;
  logic [9:0]         chosen_point;
  logic [3:0]         out_dim;
  logic signed [15:0] out_coord;
  logic               last_of_center;
  modport source (output valid, center_number, chosen_point, out_dim, out_coord,
                  last_of_center, input ready);
  modport sink (input valid, center_number, chosen_point, out_dim, out_coord,
                last_of_center, output ready);
endinterface

interface kpps_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/kmeans_plus_plus_seeding_unit.sv =====
// top level of the k-means++ seeding unit
// Loads point coordinates one word at a time (req_type 0, while idle) and answers
// each draw word (req_type 1) with the coordinates of the next chosen center, one
// result word per dimension in use, the final one flagged last_of_center. The first
// draw picks uniformly, floor(r*n/2^32). A later draw streams every point through the
// distance pipeline, one coordinate per cycle against a ring of MAX_DIMS cells that
// holds the previous center; if the kept nearest distances then sum to zero it too
// picks uniformly, else it makes a second pass over them for the weighted pick. It
// then loads the new center into the ring, then gives the results. Draws beyond the
// center limit (num_centers, capped at MAX_CENTERS) are taken with no result. A write
// to a configuration register restarts seeding; no clearing pass is needed after reset.
module kmeans_plus_plus_seeding_unit #(
  parameter int unsigned MAX_POINTS  = 1024,
  parameter int unsigned MAX_DIMS    = 16,
  parameter int unsigned MAX_CENTERS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  kpps_req_if.sink   req_i,
  kpps_res_if.source res_o,
  kpps_cfg_if.sink   cfg_i
);
  import kpps_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_POINTS);
  localparam int unsigned NW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DNW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned CW   = $clog2(MAX_CENTERS + 1);
  localparam int unsigned SQW  = 32;
  localparam int unsigned DSTW = SQW + DNW;
  localparam int unsigned TW   = DSTW + NW;
  localparam int unsigned HW   = TW - 32;
  localparam int unsigned PRW  = TW + 32;
  localparam int unsigned SAW  = PW + DW;
  localparam int unsigned SDEPTH = MAX_POINTS << DW;

  // configuration
  logic [10:0]   num_points_q;
  logic [4:0]    num_dims_q;
  logic [6:0]    num_centers_q;
  logic [NW-1:0]  n_eff;
  logic [DNW-1:0] d_eff;
  logic [CW-1:0]  limit;

  always_comb begin
    if (num_points_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_points_q) > 32'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(num_points_q);
    end
    if (num_dims_q == '0) begin
      d_eff = DNW'(1);
    end else if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
      d_eff = DNW'(MAX_DIMS);
    end else begin
      d_eff = DNW'(num_dims_q);
    end
    if (32'(num_centers_q) > 32'(MAX_CENTERS)) begin
      limit = CW'(MAX_CENTERS);
    end else begin
      limit = CW'(num_centers_q);
    end
  end

  logic cfg_acc, cfg_hit;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_hit = cfg_acc && (cfg_i.index == CFG_NUM_POINTS ||
                               cfg_i.index == CFG_NUM_DIMS ||
                               cfg_i.index == CFG_NUM_CENTERS);

  // state
  state_e state_q, state_d;
  logic [CW-1:0] cc_q;
  logic req_acc, out_acc;
  assign req_acc = req_i.valid && req_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  // pass one counters and pipeline
  logic [NW-1:0] pi_q;
  logic [DW-1:0] pj_q;
  logic s1_v_q, s2_v_q, s3_v_q;
  logic [PW-1:0] s1_i_q, s2_i_q, s3_i_q;
  logic [DW-1:0] s1_j_q;
  logic s1_last_q, s1_first_q, s2_last_q, s2_first_q;
  logic [SQW-1:0] s2_sq_q;
  logic [DSTW-1:0] s2_old_q, s3_old_q, s3_dist_q, acc_q, acc_sum, keep;
  logic [TW-1:0] total_q, cum_q, cum_new;
  logic [31:0] r_q;
  logic [31+HW:0] p_hi_q;
  logic [63:0] p_lo_q;
  logic [PRW-1:0] prod_q;
  logic [NW-1:0] p2i_q;
  logic p2v_q;
  logic [PW-1:0] p2idx_q, pick_q;
  logic [DW-1:0] fj_q, ej_q;
  logic fv_q;
  logic [31+NW:0] uni_prod;
  logic [NW-1:0] uni_idx;
  logic p1_last_issue, p2_hit, emit_use, emit_adv, p1_busy;

  // memories
  logic [SAW-1:0] st_waddr, st_raddr;
  logic st_we;
  logic [15:0] st_rdata;
  logic [PW-1:0] nr_raddr;
  logic [DSTW-1:0] nr_rdata;

  assign st_we    = state_q == ST_IDLE && req_acc && req_i.req_type == REQ_LOAD &&
                    32'(req_i.point_index) < 32'(MAX_POINTS) &&
                    32'(req_i.dim_index) < 32'(MAX_DIMS);
  assign st_waddr = {PW'(req_i.point_index), DW'(req_i.dim_index)};
  assign st_raddr = (state_q == ST_P1) ? {pi_q[PW-1:0], pj_q} : {pick_q, fj_q};
  assign nr_raddr = (state_q == ST_P2) ? p2i_q[PW-1:0] : pi_q[PW-1:0];

  kpps_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_point_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(req_i.coord),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  kpps_ram #(.WIDTH(DSTW), .DEPTH(MAX_POINTS)) u_dist_ram (
    .clk_i, .we_i(s3_v_q), .waddr_i(s3_i_q), .wdata_i(keep),
    .raddr_i(nr_raddr), .rdata_o(nr_rdata)
  );

  // ring of center coordinate cells, cell 0 is the head
  logic signed [15:0] ring_w [MAX_DIMS+1];
  logic ring_shift;
  logic signed [15:0] head;
  assign head = ring_w[0];
  assign ring_shift = fv_q || s1_v_q || (state_q == ST_EMIT && emit_adv);
  assign ring_w[MAX_DIMS] = fv_q ? st_rdata : head;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_ring
    kpps_cell u_cell (
      .clk_i, .shift_i(ring_shift), .coord_i(ring_w[k+1]), .coord_o(ring_w[k])
    );
  end

  // distance datapath
  logic signed [16:0] diff;
  logic [16:0] absd;
  logic [SQW-1:0] sq;
  logic in_dims;
  assign diff    = {st_rdata[15], st_rdata} - {head[15], head};
  assign absd    = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq      = 32'(absd[15:0]) * 32'(absd[15:0]);
  assign in_dims = 32'(s1_j_q) < 32'(d_eff);
  assign acc_sum = (s2_first_q ? '0 : acc_q) + DSTW'(s2_sq_q);
  assign keep    = (cc_q == CW'(1) || s3_dist_q < s3_old_q) ? s3_dist_q : s3_old_q;
  assign p1_last_issue = pj_q == DW'(MAX_DIMS - 1) && pi_q == n_eff - NW'(1);
  assign p1_busy = s1_v_q || s2_v_q || s3_v_q;

  // weighted pick and uniform pick
  assign cum_new  = cum_q + TW'(nr_rdata);
  assign p2_hit   = p2v_q && ({cum_new, 32'b0} >= prod_q);
  assign uni_prod = (32+NW)'(r_q) * (32+NW)'(n_eff);
  assign uni_idx  = uni_prod[32 +: NW];
  assign emit_use = 32'(ej_q) < 32'(d_eff);
  assign emit_adv = emit_use ? res_o.ready : 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.req_type == REQ_DRAW && cc_q < limit) begin
          state_d = (cc_q == '0) ? ST_UNI : ST_P1;
        end
      end
      ST_UNI:         state_d = ST_FETCH;
      ST_P1:          if (p1_last_issue) state_d = ST_P1_DRAIN;
      ST_P1_DRAIN:    if (!p1_busy) state_d = ST_MUL;
      ST_MUL:         state_d = ST_MUL2;
      ST_MUL2:        state_d = (total_q == '0) ? ST_UNI : ST_P2;
      ST_P2: begin
        if (p2_hit || (!p2v_q && p2i_q == n_eff)) state_d = ST_FETCH;
      end
      ST_FETCH:       if (fj_q == DW'(MAX_DIMS - 1)) state_d = ST_FETCH_DRAIN;
      ST_FETCH_DRAIN: state_d = ST_EMIT;
      ST_EMIT:        if (emit_adv && ej_q == DW'(MAX_DIMS - 1)) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_i.ready          = state_q == ST_IDLE;
    res_o.valid          = state_q == ST_EMIT && emit_use;
    res_o.center_number  = 6'(cc_q);
    res_o.chosen_point   = 10'(pick_q);
    res_o.out_dim        = 4'(ej_q);
    res_o.out_coord      = head;
    res_o.last_of_center = 32'(ej_q) == 32'(d_eff) - 32'd1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cc_q          <= '0;
      num_points_q  <= NUM_POINTS_RST;
      num_dims_q    <= NUM_DIMS_RST;
      num_centers_q <= NUM_CENTERS_RST;
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      p2v_q         <= 1'b0;
      fv_q          <= 1'b0;
      pi_q          <= '0;
      pj_q          <= '0;
      p2i_q         <= '0;
      fj_q          <= '0;
      ej_q          <= '0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= state_q == ST_P1;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q && s2_last_q;
      fv_q    <= state_q == ST_FETCH;
      p2v_q   <= state_q == ST_P2 && p2i_q < n_eff && !p2_hit;
      if (cfg_acc) begin
        case (cfg_i.index)
          CFG_NUM_POINTS:  num_points_q  <= cfg_i.data[10:0];
          CFG_NUM_DIMS:    num_dims_q    <= cfg_i.data[4:0];
          CFG_NUM_CENTERS: num_centers_q <= cfg_i.data[6:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        cc_q <= '0;
      end else if (state_q == ST_EMIT && state_d == ST_IDLE) begin
        cc_q <= cc_q + CW'(1);
      end
      if (state_q == ST_IDLE) begin
        pi_q <= '0;
        pj_q <= '0;
      end else if (state_q == ST_P1) begin
        pj_q <= (pj_q == DW'(MAX_DIMS - 1)) ? '0 : pj_q + DW'(1);
        if (pj_q == DW'(MAX_DIMS - 1)) pi_q <= pi_q + NW'(1);
      end
      if (state_q == ST_P2) begin
        if (p2i_q < n_eff) p2i_q <= p2i_q + NW'(1);
      end else begin
        p2i_q <= '0;
      end
      fj_q <= (state_q == ST_FETCH) ? fj_q + DW'(1) : '0;
      if (state_q == ST_EMIT) begin
        if (emit_adv) ej_q <= ej_q + DW'(1);
      end else begin
        ej_q <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_acc) r_q <= req_i.rand_fraction;
    s1_i_q     <= pi_q[PW-1:0];
    s1_j_q     <= pj_q;
    s1_last_q  <= pj_q == DW'(MAX_DIMS - 1);
    s1_first_q <= pj_q == '0;
    s2_sq_q    <= in_dims ? sq : '0;
    s2_i_q     <= s1_i_q;
    s2_last_q  <= s1_last_q;
    s2_first_q <= s1_first_q;
    s2_old_q   <= nr_rdata;
    if (s2_v_q) acc_q <= acc_sum;
    s3_dist_q  <= acc_sum;
    s3_i_q     <= s2_i_q;
    s3_old_q   <= s2_old_q;
    if (state_q == ST_IDLE) begin
      total_q <= '0;
    end else if (s3_v_q) begin
      total_q <= total_q + TW'(keep);
    end
    p_lo_q  <= 64'(r_q) * 64'(total_q[31:0]);
    p_hi_q  <= (32+HW)'(r_q) * (32+HW)'(total_q[TW-1:32]);
    if (state_q == ST_MUL2) begin
      prod_q <= PRW'(p_lo_q) + (PRW'(p_hi_q) << 32);
      cum_q  <= '0;
    end else if (p2v_q) begin
      cum_q  <= cum_new;
    end
    p2idx_q <= p2i_q[PW-1:0];
    if (state_q == ST_UNI) begin
      pick_q <= (uni_idx >= n_eff) ? PW'(n_eff - NW'(1)) : PW'(uni_idx);
    end else if (state_q == ST_P2) begin
      if (p2_hit) begin
        pick_q <= p2idx_q;
      end else if (!p2v_q && p2i_q == n_eff) begin
        pick_q <= PW'(n_eff - NW'(1));
      end
    end
  end

  // checks
  a_no_result_past_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> cc_q < limit) else $error("result beyond center count");
  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> cc_q == '0) else $error("config write did not restart seeding");
  a_emit_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> 32'(pick_q) < 32'(n_eff)) else $error("pick out of range");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && res_o.valid)) else $error("accepting while emitting");
endmodule

// ===== design/kpps_ram.sv =====
// generic single write port ram with registered read
module kpps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/kpps_cell.sv =====
// one cell of the center coordinate ring
module kpps_cell (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic signed [15:0]       coord_i,
  output logic signed [15:0]       coord_o
);
  logic signed [15:0] coord_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      coord_q <= coord_i;
    end
  end

  assign coord_o = coord_q;
endmodule

// ===== verif/kmeans_plus_plus_seeding_unit_tb.sv =====
// self-checking testbench of the k-means++ seeding unit
module kmeans_plus_plus_seeding_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kpps_pkg::*;

  localparam int unsigned MaxPts  = 1024;
  localparam int unsigned MaxDims = 16;
  localparam int unsigned MaxCtrs = 64;
  localparam int unsigned CycleLimit = 1500000;

  // one request word as the sender queues it
  typedef struct {
    logic               req_type;
    logic [9:0]         point_index;
    logic [3:0]         dim_index;
    logic signed [15:0] coord;
    logic [31:0]        rand_fraction;
  } req_word_t;

  // one center coordinate as the block should emit it
  typedef struct {
    logic [5:0]         center_number;
    logic [9:0]         chosen_point;
    logic [3:0]         out_dim;
    logic signed [15:0] out_coord;
    logic               last_of_center;
  } center_word_t;

  logic clk_i;
  logic rst_ni;

  kpps_req_if req ();
  kpps_res_if res ();
  kpps_cfg_if cfg ();

  kmeans_plus_plus_seeding_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res),
    .cfg_i (cfg)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state: our own copy of the point store and seeding progress
  logic signed [15:0] pts_mem [MaxPts][MaxDims];
  longint unsigned    near_dist [MaxPts];
  logic signed [15:0] last_center [MaxDims];
  int unsigned        n_chosen;
  logic [10:0]        cfg_points;
  logic [4:0]         cfg_dims;
  logic [6:0]         cfg_centers;

  req_word_t    pending_words[$];
  center_word_t expected_coords[$];

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned draws_sent;
  int unsigned loads_sent;
  int unsigned cycles;
  bit          no_gaps;       // sender idling off for a stretch
  int unsigned stall_reqs;    // long receiver hold-offs asked for
  int unsigned stall_served;

  function automatic int unsigned eff_points();
    if (cfg_points < 1) return 1;
    return (cfg_points > MaxPts) ? MaxPts : cfg_points;
  endfunction

  function automatic int unsigned eff_dims();
    if (cfg_dims < 1) return 1;
    return (cfg_dims > MaxDims) ? MaxDims : cfg_dims;
  endfunction

  function automatic int unsigned uniform_index(logic [31:0] r, int unsigned n);
    logic [63:0] prod;
    prod = {32'd0, r} * 64'(n);
    prod = prod >> 32;
    return (prod >= n) ? n - 1 : int'(prod);
  endfunction

  // choose the next center for draw fraction r and queue its coordinates
  task automatic predict_center(logic [31:0] r);
    int unsigned n, d, lim, pick;
    longint unsigned total, cum, sq_sum, a;
    logic [127:0] lhs, rhs;
    int signed diff;
    center_word_t cw;
    n = eff_points();
    d = eff_dims();
    lim = (cfg_centers > MaxCtrs) ? MaxCtrs : cfg_centers;
    if (n_chosen >= lim) return;
    if (n_chosen == 0) begin
      pick = uniform_index(r, n);
    end else begin
      total = 0;
      for (int i = 0; i < n; i++) begin
        sq_sum = 0;
        for (int j = 0; j < d; j++) begin
          diff = int'(pts_mem[i][j]) - int'(last_center[j]);
          a = (diff < 0) ? longint'(-diff) : longint'(diff);
          sq_sum += a * a;
        end
        if (n_chosen == 1 || sq_sum < near_dist[i]) near_dist[i] = sq_sum;
        total += near_dist[i];
      end
      if (total == 0) begin
        pick = uniform_index(r, n);
      end else begin
        // exact test r * total <= cum * 2^32
        pick = n - 1;
        cum = 0;
        for (int i = 0; i < n; i++) begin
          cum += near_dist[i];
          lhs = 128'(r) * 128'(total);
          rhs = 128'(cum) << 32;
          if (lhs <= rhs) begin
            pick = i;
            break;
          end
        end
      end
    end
    for (int j = 0; j < MaxDims; j++) last_center[j] = pts_mem[pick][j];
    for (int j = 0; j < d; j++) begin
      cw.center_number  = n_chosen[5:0];
      cw.chosen_point   = pick[9:0];
      cw.out_dim        = j[3:0];
      cw.out_coord      = last_center[j];
      cw.last_of_center = (j == d - 1);
      expected_coords.push_back(cw);
    end
    n_chosen++;
  endtask

  // handshakes seen at the rising edge, used by the falling-edge drivers
  logic req_fire, res_fire;
  always @(posedge clk_i) begin
    req_fire <= req.valid && req.ready;
    res_fire <= res.valid && res.ready;
  end

  // monitor: feed the predictor with accepted words, check emitted ones
  always @(posedge clk_i) begin
    center_word_t exp_w;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_NUM_POINTS:  cfg_points  = cfg.data[10:0];
          CFG_NUM_DIMS:    cfg_dims    = cfg.data[4:0];
          CFG_NUM_CENTERS: cfg_centers = cfg.data[6:0];
          default: ;
        endcase
        n_chosen = 0;
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LOAD) pts_mem[req.point_index][req.dim_index] = req.coord;
        else predict_center(req.rand_fraction);
      end
      if (res.valid && res.ready) begin
        words_checked++;
        if (expected_coords.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: center %0d point %0d dim %0d coord %0d",
                     res.center_number, res.chosen_point, res.out_dim, res.out_coord);
        end else begin
          exp_w = expected_coords.pop_front();
          if (res.center_number !== exp_w.center_number ||
              res.chosen_point !== exp_w.chosen_point || res.out_dim !== exp_w.out_dim ||
              res.out_coord !== exp_w.out_coord ||
              res.last_of_center !== exp_w.last_of_center) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp c%0d p%0d d%0d v%0d l%0d, got c%0d p%0d d%0d v%0d l%0d",
                       exp_w.center_number, exp_w.chosen_point, exp_w.out_dim,
                       exp_w.out_coord, exp_w.last_of_center, res.center_number,
                       res.chosen_point, res.out_dim, res.out_coord, res.last_of_center);
          end
        end
      end
    end
  end

  // sender: random gap before each word, popped from the pending queue
  int unsigned send_gap;
  always @(negedge clk_i) begin
    req_word_t w;
    if (rst_ni && (!req.valid || req_fire)) begin
      if (send_gap > 0) begin
        req.valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        req.valid         <= 1'b1;
        req.req_type      <= w.req_type;
        req.point_index   <= w.point_index;
        req.dim_index     <= w.dim_index;
        req.coord         <= w.coord;
        req.rand_fraction <= w.rand_fraction;
        send_gap = no_gaps ? 0 : $urandom_range(0, 5);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall per word, plus long hold-offs on request
  int unsigned sink_wait, hold_cnt;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_fire) sink_wait = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else if (stall_reqs != stall_served) begin
        stall_served++;
        hold_cnt = 400;
        res.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_load(int unsigned p, int unsigned k, logic signed [15:0] v);
    req_word_t w;
    w.req_type = REQ_LOAD;
    w.point_index = p[9:0];
    w.dim_index = k[3:0];
    w.coord = v;
    w.rand_fraction = $urandom();
    pending_words.push_back(w);
    loads_sent++;
  endtask

  task automatic push_draw(logic [31:0] r);
    req_word_t w;
    w.req_type = REQ_DRAW;
    w.point_index = $urandom();
    w.dim_index = $urandom();
    w.coord = $urandom();
    w.rand_fraction = r;
    pending_words.push_back(w);
    draws_sent++;
  endtask

  // every dimension is loaded so the block never reads an unwritten cell
  task automatic load_points(int unsigned n, int unsigned spread);
    logic signed [15:0] v;
    for (int p = 0; p < n; p++)
      for (int k = 0; k < MaxDims; k++) begin
        case ($urandom_range(0, 9))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          default: v = (spread == 0) ? 16'sd0 : 16'($urandom_range(0, 2 * spread) - spread);
        endcase
        push_load(p, k, v);
      end
  endtask

  // hold the sender until every expected word is in and the block is quiet
  task automatic drain();
    while (pending_words.size() != 0 || req.valid || expected_coords.size() != 0)
      @(posedge clk_i);
    repeat (eff_points() * 20 + 64) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic setup(logic [15:0] n, logic [15:0] d, logic [15:0] k);
    drain();
    write_reg(CFG_NUM_POINTS, n);
    write_reg(CFG_NUM_DIMS, d);
    write_reg(CFG_NUM_CENTERS, k);
  endtask

  initial begin
    int unsigned n, d, k, rand_draws, cnt;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.req_type = REQ_LOAD;
    req.point_index = '0;
    req.dim_index = '0;
    req.coord = '0;
    req.rand_fraction = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    cfg_points = NUM_POINTS_RST;
    cfg_dims = NUM_DIMS_RST;
    cfg_centers = NUM_CENTERS_RST;
    n_chosen = 0;
    mismatches = 0;
    words_checked = 0;
    draws_sent = 0;
    loads_sent = 0;
    cycles = 0;
    no_gaps = 0;
    stall_reqs = 0;
    stall_served = 0;
    send_gap = 0;
    sink_wait = 0;
    hold_cnt = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small set, fraction extremes, a draw past the center count,
    // a reload while seeding, and a long receiver hold-off
    setup(3, 3, 3);
    load_points(3, 30000);
    stall_reqs++;
    push_draw(32'h0);
    push_draw(32'hffff_ffff);
    push_load(2, 1, 16'sh7fff);
    push_draw($urandom());
    push_draw($urandom());

    // registers below range count as one; zero centers gives nothing
    setup(0, 0, 0);
    push_draw($urandom());
    // single point: later draws see a zero total
    setup(1, 0, 3);
    push_draw(32'hffff_ffff);
    push_draw(32'h8000_0000);
    push_draw(32'h0);

    // two points equal in the one dimension in use: zero total, uniform pick
    setup(2, 1, 3);
    push_load(0, 0, 16'sd77);
    push_load(1, 0, 16'sd77);
    push_draw($urandom());
    push_draw(32'hffff_ffff);
    push_draw($urandom());

    // saturating registers: the uniform pick lands on a loaded point
    setup(16'h7ff, 16'h1f, 1);
    push_draw(32'h0080_0000);
    push_draw($urandom());

    // center count saturates at the maximum, picks run out of distinct points
    setup(3, 1, 16'h7f);
    no_gaps = 1;
    for (int i = 0; i < MaxCtrs + 1; i++) push_draw($urandom());
    drain();
    no_gaps = 0;

    // random settings over the loaded points, with the odd reload
    rand_draws = 0;
    while (rand_draws < 8) begin
      n = $urandom_range(2, 3);
      d = $urandom_range(1, 16);
      k = $urandom_range(1, 3);
      setup(16'(n), 16'(d), 16'(k));
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) stall_reqs++;
      cnt = k + $urandom_range(0, 1);
      for (int i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 2) == 0)
          push_load($urandom_range(0, n - 1), $urandom_range(0, 15), 16'($urandom()));
        push_draw($urandom());
        rand_draws++;
      end
    end

    drain();
    if (expected_coords.size() != 0) mismatches += expected_coords.size();
    $display("covered %0d draws and %0d loads, %0d center words checked, %0d mismatches",
             draws_sent, loads_sent, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kpps_pkg.sv
design/kpps_if.sv
design/kpps_ram.sv
design/kpps_cell.sv
design/kmeans_plus_plus_seeding_unit.sv
verif/kmeans_plus_plus_seeding_unit_tb.sv
